>>> hdl/joint_move_interpolator_defines.svh
// assertion macros used by joint_move_interpolator.sv
`ifndef JOINT_MOVE_INTERPOLATOR_DEFINES_SVH
`define JOINT_MOVE_INTERPOLATOR_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define JMI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence required in the cycle after the trigger
`define JMI_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> hdl/jmi_pkg.sv
package jmi_pkg;

  // joint count and limits
  localparam int NUM_JOINTS    = 5;
  localparam int MAX_STEPS_DEF = 64;

  // fixed-point constants
  localparam logic [15:0] VMAX_Q       = 16'd48899;
  localparam logic signed [16:0] OFFSET_Q = 17'sd10723;
  localparam logic [31:0] START_LAG_MS = 32'd100;
  localparam logic [9:0]  STEP_RESET   = 10'd80;
  localparam logic [9:0]  MS_PER_S     = 10'd1000;

  // shared divider sizes
  localparam int DIV_W  = 51;
  localparam int QCNT_W = 5;
  localparam int DEN_W  = 43;

  typedef logic signed [15:0] ang_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  dsh;
    logic [QCNT_W-1:0] nbits;
  } div_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [16:0]      q;
    logic [DIV_W-1:0] rem;
  } div_stat_t;

endpackage

>>> hdl/joint_move_interpolator.sv
// joint move interpolator
// input channel (in_valid/in_ready): one move command carrying five goal
// angles, a speed rate, the current time and five measured angles.
// output channel (out_valid/out_ready): n setpoints per move, 1 <= n <=
// MAX_STEPS, each with five angles, five joint speeds, a time stamp and a
// last flag on the final setpoint.
// cfg_we/cfg_data write the step time in ms; write only while idle.
// the setup for one move runs before the first setpoint is shown: a
// shared restoring divider, one quotient bit per cycle, runs an 8-bit step
// count division, then per joint a 17-bit speed division and a 16-bit
// increment division, plus multiply and compare steps.
// after a setpoint is taken, the next one is built in S_ADV and S_SET.
// in_ready is low from acceptance until the last setpoint is taken.
// when out_ready is low the setpoint holds and the sequencer waits.
// reset clears the plan end time and angles to zero, sets the step time
// to 80 ms and returns to idle.
`include "joint_move_interpolator_defines.svh"

module joint_move_interpolator #(
  parameter int MAX_STEPS = jmi_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] goal_a,
  input  logic signed [15:0] goal_b,
  input  logic signed [15:0] goal_c,
  input  logic signed [15:0] goal_d,
  input  logic signed [15:0] goal_e,
  input  logic [16:0]        speed_rate,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] meas_a,
  input  logic signed [15:0] meas_b,
  input  logic signed [15:0] meas_c,
  input  logic signed [15:0] meas_d,
  input  logic signed [15:0] meas_e,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] set_a,
  output logic signed [15:0] set_b,
  output logic signed [15:0] set_c,
  output logic signed [15:0] set_d,
  output logic signed [15:0] set_e,
  output logic [15:0]        vel_a,
  output logic [15:0]        vel_b,
  output logic [15:0]        vel_c,
  output logic [15:0]        vel_d,
  output logic [15:0]        vel_e,
  output logic [31:0]        stamp_ms,
  output logic               last
);
  import jmi_pkg::*;

  localparam int KW = $clog2(MAX_STEPS + 1);
  localparam int QB = KW + 1;
  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MAX, S_MUL, S_NDIV, S_NWAIT, S_VMUL, S_VDIV,
    S_VWAIT, S_IDIV, S_IWAIT, S_ADV, S_SET, S_OUT
  } state_t;

  state_t state;

  logic [9:0]         step_ms;
  logic [31:0]        planned_until;
  ang_t               planned [NUM_JOINTS];
  ang_t               goal_q  [NUM_JOINTS];
  ang_t               start_q [NUM_JOINTS];
  logic               neg     [NUM_JOINTS];
  logic [15:0]        mag     [NUM_JOINTS];
  logic [15:0]        vel     [NUM_JOINTS];
  logic [15:0]        q0      [NUM_JOINTS];
  logic [KW-1:0]      r0      [NUM_JOINTS];
  logic [15:0]        qa      [NUM_JOINTS];
  logic [KW:0]        ra      [NUM_JOINTS];
  ang_t               set_r   [NUM_JOINTS];
  logic [32:0]        kr;
  logic [15:0]        maxd;
  logic [DEN_W-1:0]   den;
  logic [25:0]        numn;
  logic [48:0]        prod;
  logic [KW-1:0]      n_steps;
  logic [KW-1:0]      k;
  logic [JW-1:0]      j;
  logic [31:0]        stamp;

  ang_t goal_in [NUM_JOINTS];
  ang_t meas_in [NUM_JOINTS];

  div_cmd_t  cmd;
  div_stat_t stat;
  logic [QB-1:0] q_n;

  assign goal_in = '{goal_a, goal_b, goal_c, goal_d, goal_e};
  assign meas_in = '{meas_a, meas_b, meas_c, meas_d, meas_e};
  assign q_n     = stat.q[QB-1:0];

  // shared divider
  jmi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // divider command per sequencer step
  always_comb begin
    cmd = '0;
    case (state)
      S_NDIV: begin
        cmd.start = 1'b1;
        cmd.num   = DIV_W'({numn, 16'b0});
        cmd.dsh   = DIV_W'(den) << (QB - 1);
        cmd.nbits = QCNT_W'(QB);
      end
      S_VDIV: begin
        cmd.start = 1'b1;
        cmd.num   = DIV_W'(prod[48:16]);
        cmd.dsh   = DIV_W'(maxd) << 16;
        cmd.nbits = QCNT_W'(17);
      end
      S_IDIV: begin
        cmd.start = 1'b1;
        cmd.num   = DIV_W'(mag[j]);
        cmd.dsh   = DIV_W'(n_steps) << 15;
        cmd.nbits = QCNT_W'(16);
      end
      default: cmd = '0;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ms <= STEP_RESET;
    end else if (cfg_we) begin
      step_ms <= cfg_data;
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      planned_until <= '0;
      for (int i = 0; i < NUM_JOINTS; i++) planned[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < NUM_JOINTS; i++) begin
              logic signed [16:0] gs;
              gs = 17'(goal_in[i]) + OFFSET_Q;
              if (gs > 17'sd32767)       goal_q[i] <= 16'sh7FFF;
              else if (gs < -17'sd32768) goal_q[i] <= 16'sh8000;
              else                       goal_q[i] <= gs[15:0];
              start_q[i] <= (planned_until > now_ms) ? planned[i] : meas_in[i];
            end
            stamp <= (planned_until > now_ms) ? planned_until : now_ms + START_LAG_MS;
            kr    <= 33'(VMAX_Q) * 33'(speed_rate);
            state <= S_PREP;
          end
        end
        S_PREP: begin
          for (int i = 0; i < NUM_JOINTS; i++) begin
            logic signed [16:0] d;
            d = 17'(goal_q[i]) - 17'(start_q[i]);
            neg[i] <= d[16];
            mag[i] <= d[16] ? 16'(-d) : d[15:0];
          end
          maxd  <= '0;
          j     <= '0;
          state <= S_MAX;
        end
        S_MAX: begin
          if (mag[j] > maxd) maxd <= mag[j];
          if (j == JW'(NUM_JOINTS - 1)) state <= S_MUL;
          else j <= j + JW'(1);
        end
        S_MUL: begin
          den   <= DEN_W'(kr) * DEN_W'(step_ms);
          numn  <= 26'(maxd) * 26'(MS_PER_S);
          j     <= '0;
          state <= S_NDIV;
        end
        S_NDIV: state <= S_NWAIT;
        S_NWAIT: begin
          if (stat.done) begin
            if (den == '0 || stat.rem >= DIV_W'(den) || q_n > QB'(MAX_STEPS))
              n_steps <= KW'(MAX_STEPS);
            else if (q_n == '0)
              n_steps <= KW'(1);
            else
              n_steps <= q_n[KW-1:0];
            state <= S_VMUL;
          end
        end
        S_VMUL: begin
          prod <= 49'(kr) * 49'(mag[j]);
          if (maxd == '0) begin
            vel[j] <= '0;
            state  <= S_IDIV;
          end else begin
            state  <= S_VDIV;
          end
        end
        S_VDIV: state <= S_VWAIT;
        S_VWAIT: begin
          if (stat.done) begin
            vel[j] <= stat.q[16] ? 16'hFFFF : stat.q[15:0];
            state  <= S_IDIV;
          end
        end
        S_IDIV: state <= S_IWAIT;
        S_IWAIT: begin
          if (stat.done) begin
            q0[j] <= stat.q[15:0];
            r0[j] <= stat.rem[KW-1:0];
            if (j == JW'(NUM_JOINTS - 1)) begin
              for (int i = 0; i < NUM_JOINTS; i++) begin
                qa[i] <= '0;
                ra[i] <= '0;
              end
              k     <= KW'(1);
              state <= S_ADV;
            end else begin
              j     <= j + JW'(1);
              state <= S_VMUL;
            end
          end
        end
        S_ADV: begin
          // running quotient and remainder of |d| * k / n
          for (int i = 0; i < NUM_JOINTS; i++) begin
            logic [KW:0] rs;
            rs = ra[i] + (KW+1)'(r0[i]);
            if (rs >= (KW+1)'(n_steps)) begin
              ra[i] <= rs - (KW+1)'(n_steps);
              qa[i] <= qa[i] + q0[i] + 16'd1;
            end else begin
              ra[i] <= rs;
              qa[i] <= qa[i] + q0[i];
            end
          end
          stamp <= stamp + 32'(step_ms);
          state <= S_SET;
        end
        S_SET: begin
          for (int i = 0; i < NUM_JOINTS; i++)
            set_r[i] <= neg[i] ? start_q[i] - ang_t'(qa[i]) : start_q[i] + ang_t'(qa[i]);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (k == n_steps) begin
              planned_until <= stamp;
              for (int i = 0; i < NUM_JOINTS; i++) planned[i] <= set_r[i];
              state <= S_IDLE;
            end else begin
              k     <= k + KW'(1);
              state <= S_ADV;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output ports
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign last      = (k == n_steps);
  assign stamp_ms  = stamp;
  assign set_a = set_r[0];
  assign set_b = set_r[1];
  assign set_c = set_r[2];
  assign set_d = set_r[3];
  assign set_e = set_r[4];
  assign vel_a = vel[0];
  assign vel_b = vel[1];
  assign vel_c = vel[2];
  assign vel_d = vel[3];
  assign vel_e = vel[4];

  // checks
  `JMI_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while setpoints pending")
  `JMI_ASSERT(a_n_range, out_valid |-> (n_steps != '0 && n_steps <= KW'(MAX_STEPS)), "step count out of range")
  `JMI_ASSERT(a_k_range, out_valid |-> (k != '0 && k <= n_steps), "step index beyond step count")
  `JMI_ASSERT_NEXT(a_last_idle, out_valid && out_ready && last, in_ready, "not idle after final item")
  `JMI_ASSERT_NEXT(a_div_start, cmd.start, stat.busy, "divider did not start")

endmodule

>>> hdl/jmi_div.sv
module jmi_div (
  input  logic               clk,
  input  logic               rst,
  input  jmi_pkg::div_cmd_t  cmd,
  output jmi_pkg::div_stat_t stat
);
  import jmi_pkg::*;

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [16:0]       q;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  // control: busy while bits remain, done pulses after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == QCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one restoring compare-subtract per cycle
  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      rem <= cmd.num;
      dsh <= cmd.dsh;
      q   <= '0;
      cnt <= cmd.nbits;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[15:0], 1'b1};
      end else begin
        q   <= {q[15:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - QCNT_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.q    = q;
  assign stat.rem  = rem;

endmodule

>>> sim/joint_move_interpolator_tb.sv
module joint_move_interpolator_tb;
  import jmi_pkg::*;

  localparam int     CYCLE_LIMIT = 10000000;
  localparam int     PHASE_ITEMS = 75;
  localparam int     STEP_CAP    = 64;
  localparam longint VMAX        = 48899;
  localparam longint GOAL_OFS    = 10723;
  localparam longint LAG_MS      = 100;

  typedef logic [NUM_JOINTS-1:0][15:0] joints_t;

  // one setpoint as the block emits it
  typedef struct packed {
    joints_t     ang;
    joints_t     vel;
    logic [31:0] stamp;
    logic        last;
  } setpoint_t;

  // one move command, with an optional typed-in single setpoint
  typedef struct packed {
    joints_t     goal;
    logic [16:0] rate;
    logic [31:0] now;
    joints_t     meas;
    logic        fixed;
    logic [15:0] fix_ang;
    logic [31:0] fix_stamp;
  } move_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  joints_t     goal = '0;
  joints_t     meas = '0;
  logic [16:0] speed_rate = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] set_a, set_b, set_c, set_d, set_e;
  logic [15:0] vel_a, vel_b, vel_c, vel_d, vel_e;
  logic [31:0] stamp_ms;
  logic        last;

  // predictor state
  logic [31:0] plan_end = '0;
  longint      plan_ang [NUM_JOINTS];
  logic [9:0]  step_ms = STEP_RESET;

  setpoint_t   setpoint_q[$];
  move_t       directed_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          steady = 1'b0;
  int          stall_left = 0;
  logic [31:0] clock_ms = 32'd20000;

  always #5 clk = ~clk;

  joint_move_interpolator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .goal_a(goal[0]), .goal_b(goal[1]), .goal_c(goal[2]), .goal_d(goal[3]),
    .goal_e(goal[4]), .speed_rate(speed_rate), .now_ms(now_ms),
    .meas_a(meas[0]), .meas_b(meas[1]), .meas_c(meas[2]), .meas_d(meas[3]),
    .meas_e(meas[4]),
    .out_valid(out_valid), .out_ready(out_ready),
    .set_a(set_a), .set_b(set_b), .set_c(set_c), .set_d(set_d), .set_e(set_e),
    .vel_a(vel_a), .vel_b(vel_b), .vel_c(vel_c), .vel_d(vel_d), .vel_e(vel_e),
    .stamp_ms(stamp_ms), .last(last)
  );

  // expand one move into its setpoints and advance the plan end
  task automatic plan_move(input move_t m);
    longint    s [NUM_JOINTS];
    longint    d [NUM_JOINTS];
    longint    mag [NUM_JOINTS];
    longint    g, maxd, den, n, v, a;
    logic [31:0] t0;
    joints_t   vel;
    setpoint_t sp;
    maxd = 0;
    if (plan_end > m.now) t0 = plan_end;
    else t0 = m.now + 32'(LAG_MS);
    for (int i = 0; i < NUM_JOINTS; i++) begin
      g = longint'($signed(m.goal[i])) + GOAL_OFS;
      if (g > 32767) g = 32767;
      s[i] = (plan_end > m.now) ? plan_ang[i] : longint'($signed(m.meas[i]));
      d[i] = g - s[i];
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
      if (mag[i] > maxd) maxd = mag[i];
    end
    for (int i = 0; i < NUM_JOINTS; i++) begin
      if (maxd == 0) v = 0;
      else v = (VMAX * longint'(m.rate) * mag[i]) / (65536 * maxd);
      vel[i] = (v > 65535) ? 16'hFFFF : v[15:0];
    end
    den = VMAX * longint'(m.rate) * longint'(step_ms);
    if (den == 0) n = STEP_CAP;
    else n = (maxd * 1000 * 65536) / den;
    if (n > STEP_CAP) n = STEP_CAP;
    if (n < 1) n = 1;
    for (int k = 1; k <= n; k++) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        a = s[i] + (d[i] * k) / n;
        sp.ang[i] = a[15:0];
        if (k == n) plan_ang[i] = a;
      end
      sp.vel = vel;
      sp.stamp = t0 + 32'(k) * 32'(step_ms);
      sp.last = (k == n);
      if (k == n) plan_end = sp.stamp;
      setpoint_q.push_back(sp);
    end
  endtask

  // mostly short gaps, a few long ones, none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_move(input move_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    goal = m.goal;
    meas = m.meas;
    speed_rate = m.rate;
    now_ms = m.now;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    plan_move(m);
    // zero-delta rows carry their single setpoint typed in
    if (m.fixed) begin
      void'(setpoint_q.pop_back());
      setpoint_q.push_back({{NUM_JOINTS{m.fix_ang}}, {NUM_JOINTS{16'd0}}, m.fix_stamp, 1'b1});
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (setpoint_q.size() != 0) @(negedge clk);
  endtask

  // step time is written only with the block idle
  task automatic write_step(input logic [9:0] v);
    in_valid = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);
    cfg_data = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    step_ms = v;
  endtask

  function automatic move_t mk_move(input joints_t g, input logic [16:0] r,
                                    input logic [31:0] t, input joints_t ms);
    move_t m;
    m = '0;
    m.goal = g;
    m.rate = r;
    m.now = t;
    m.meas = ms;
    return m;
  endfunction

  // random move: mostly goals near the current plan, some wild ones
  function automatic move_t rand_move();
    move_t m;
    int    r;
    m = '0;
    r = $urandom_range(0, 99);
    for (int i = 0; i < NUM_JOINTS; i++) begin
      if (r < 65)
        m.goal[i] = 16'(plan_ang[i] - GOAL_OFS + $signed($urandom_range(0, 4095)) - 2048);
      else
        m.goal[i] = 16'($urandom());
      m.meas[i] = ($urandom_range(0, 3) == 0) ? 16'(m.goal[i] + GOAL_OFS) : 16'($urandom());
    end
    r = $urandom_range(0, 99);
    if (r < 70) m.rate = 17'($urandom_range(1, 65536));
    else if (r < 85) m.rate = 17'($urandom_range(1, 4096));
    else if (r < 92) m.rate = 17'd65536;
    else m.rate = 17'($urandom_range(0, 131071));
    clock_ms = clock_ms + $urandom_range(0, 3000);
    m.now = ($urandom_range(0, 9) == 0) ? $urandom() : clock_ms;
    return m;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready = 1'b0;
    end else if (steady) begin
      out_ready = 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          stall_left = $urandom_range(10, 40);
          out_ready = 1'b0;
        end
        1, 2, 3, 4: out_ready = 1'b0;
        default: out_ready = 1'b1;
      endcase
    end
  end

  // compare each taken setpoint with the oldest expected one
  always @(posedge clk) begin
    setpoint_t sp;
    if (!rst && out_valid && out_ready) begin
      if (setpoint_q.size() == 0) begin
        $display("%0t unexpected setpoint stamp %0d", $time, stamp_ms);
        errors++;
      end else begin
        sp = setpoint_q.pop_front();
        if ({set_e, set_d, set_c, set_b, set_a} !== sp.ang) begin
          $display("%0t angles expected %h actual %h", $time, sp.ang,
                   {set_e, set_d, set_c, set_b, set_a});
          errors++;
        end
        if ({vel_e, vel_d, vel_c, vel_b, vel_a} !== sp.vel) begin
          $display("%0t speeds expected %h actual %h", $time, sp.vel,
                   {vel_e, vel_d, vel_c, vel_b, vel_a});
          errors++;
        end
        if (stamp_ms !== sp.stamp) begin
          $display("%0t stamp expected %0d actual %0d", $time, sp.stamp, stamp_ms);
          errors++;
        end
        if (last !== sp.last) begin
          $display("%0t last expected %b actual %b", $time, sp.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    move_t   m;
    joints_t mixed;
    int      waited;
    for (int i = 0; i < NUM_JOINTS; i++) plan_ang[i] = 0;
    mixed = {16'hFFFF, 16'h0001, 16'h0000, 16'h8000, 16'h7FFF};

    // zero-delta moves with typed-in results, then extremes
    m = mk_move({NUM_JOINTS{16'(-10723)}}, 17'd65536, 32'd0, '0);
    m.fixed = 1'b1; m.fix_ang = 16'd0; m.fix_stamp = 32'd180;
    directed_q.push_back(m);
    m = mk_move({NUM_JOINTS{16'h7FFF}}, 17'd1, 32'd1000, {NUM_JOINTS{16'h7FFF}});
    m.fixed = 1'b1; m.fix_ang = 16'h7FFF; m.fix_stamp = 32'd1180;
    directed_q.push_back(m);
    m = mk_move({NUM_JOINTS{16'h8000}}, 17'h1FFFF, 32'd5000, {NUM_JOINTS{16'(-22045)}});
    m.fixed = 1'b1; m.fix_ang = 16'(-22045); m.fix_stamp = 32'd5180;
    directed_q.push_back(m);
    directed_q.push_back(mk_move(mixed, 17'd65536, 32'd10000, ~mixed));
    directed_q.push_back(mk_move(~mixed, 17'd0, 32'd20000, mixed));
    directed_q.push_back(mk_move(mixed, 17'h1FFFF, 32'd40000, mixed));
    directed_q.push_back(mk_move(~mixed, 17'd1, 32'd50000, {NUM_JOINTS{16'h8000}}));
    // plan end lies ahead of now: continue from the plan
    directed_q.push_back(mk_move(mixed, 17'd30000, 32'd50001, '0));
    directed_q.push_back(mk_move({16'd5, 16'd0, 16'h7000, 16'd3, 16'd9}, 17'd65536,
                                 32'hFFFFFFFF, {NUM_JOINTS{16'h1234}}));
    // stamps wrap past 2^32
    directed_q.push_back(mk_move(~mixed, 17'd65535, 32'hFFFFFFC0, mixed));
    directed_q.push_back(mk_move(mixed, 17'd2, 32'd0, ~mixed));
    directed_q.push_back(mk_move({NUM_JOINTS{16'h5555}}, 17'h0AAAA, 32'hAAAAAAAA,
                                 {NUM_JOINTS{16'hAAAA}}));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_q[j]) send_move(directed_q[j]);

    // random phases over several step times, extremes included
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_step(10'd1000);
        1: write_step(10'd1);
        2: write_step(10'd0);
        3: write_step(10'h3FF);
        4: write_step(10'($urandom_range(1, 1000)));
        default: write_step(STEP_RESET);
      endcase
      steady = (p == 4);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // hold off once until the block has drained
        if (p == 2 && j == PHASE_ITEMS / 2) begin
          in_valid = 1'b0;
          wait_drained();
        end
        send_move(rand_move());
      end
    end
    in_valid = 1'b0;
    steady = 1'b0;

    waited = 0;
    while (setpoint_q.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (300) @(negedge clk);
    if (errors == 0 && setpoint_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (setpoint_q.size() != 0)
        $display("%0t %0d setpoints never arrived", $time, setpoint_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
